// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define MMR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Same, with a message of its own.
`define MMR_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

`endif

// ===== rtl/mmr_pkg.sv =====
package mmr_pkg;

  // Fixed width of the word fields on the ports.
  localparam int DATA_W = 64;

  // Command codes carried in the action field.
  typedef enum logic [1:0] {
    ACT_DIVIDEND = 2'd0,
    ACT_DIVISOR  = 2'd1,
    ACT_COMPUTE  = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [5:0]        word_index;
    logic [DATA_W-1:0] word_value;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] remainder_word;
    logic [5:0]        out_index;
    logic              last_word;
    logic              zero_divisor;
  } out_word_t;

endpackage

// ===== rtl/mmr_ram.sv =====
module mmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/multiword_modular_reduction.sv =====
// Multiword modular reduction. Dividend and divisor words are loaded one per
// cycle while the input is not stalled (action 0 and 1). A compute command
// (action 2) reduces the dividend modulo the divisor by restoring
// shift-and-subtract division and then emits one remainder word per index,
// last_word set on the top one. A compute first clears the remainder memory
// and checks the divisor for zero, then divides, walking the remainder memory
// word by word once for every dividend bit, and then emits the words, each
// held while the output stalls. A zero divisor skips the division and returns
// the dividend with zero_divisor set. The input is stalled for the whole
// compute.
module multiword_modular_reduction #(
  parameter int WORD_BITS = 64,
  parameter int MAX_WORDS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mmr_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mmr_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int BW = $clog2(WORD_BITS);
  localparam int DW = mmr_pkg::DATA_W;
  localparam logic [6:0] MAXW = 7'(MAX_WORDS);
  localparam logic [BW-1:0] TOPB = BW'(WORD_BITS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_BIT  = 6'b000100,
    S_ERD  = 6'b001000,
    S_ELD  = 6'b010000,
    S_EWT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [6:0]          wiu_q;
  logic [AW-1:0]       nm1_q, nm1_d;
  logic [AW-1:0]       ic_q, ic_d;
  logic                iss_q, iss_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       rd_idx_q;
  logic [AW-1:0]       dword_q, dword_d;
  logic [BW-1:0]       bpos_q, bpos_d;
  logic                carry_q, carry_d;
  logic                borrow_q, borrow_d;
  logic                use_t_q, use_t_d;
  logic                nz_q, nz_d;
  logic                zero_q, zero_d;
  logic                out_vld_q, out_vld_d;
  mmr_pkg::out_word_t  out_q, out_d;

  logic                in_acc;
  logic [6:0]          n7;
  logic [AW-1:0]       dvd_raddr, wr_addr;
  logic                idx_ok;
  logic [WORD_BITS-1:0] dvd_rd, dvs_rd;
  logic [2*WORD_BITS-1:0] rem_rd, rem_wd;
  logic                rem_we;
  logic [WORD_BITS-1:0] rsel, s_w, t_w;
  logic                cin, bin, bo;
  logic                first_w, last_w;

  // Word count, clamped to the range the memories hold.
  always_comb begin
    n7 = wiu_q;
    if (n7 == 7'd0) n7 = 7'd1;
    if (n7 > MAXW) n7 = MAXW;
  end

  assign in_acc  = in_valid_i && !in_stall_o;
  assign idx_ok  = {1'b0, in_word_i.word_index} < MAXW;
  assign wr_addr = AW'(in_word_i.word_index);

  // Operand memories and the remainder memory holding both the shifted
  // value and the value after subtraction, side by side.
  assign dvd_raddr = (state_q == S_BIT) ? dword_q : ic_q;

  mmr_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_dvd_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_word_i.action == mmr_pkg::ACT_DIVIDEND && idx_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_word_i.word_value[WORD_BITS-1:0]),
    .raddr_i (dvd_raddr),
    .rdata_o (dvd_rd)
  );

  mmr_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_dvs_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_word_i.action == mmr_pkg::ACT_DIVISOR && idx_ok),
    .waddr_i (wr_addr),
    .wdata_i (in_word_i.word_value[WORD_BITS-1:0]),
    .raddr_i (ic_q),
    .rdata_o (dvs_rd)
  );

  mmr_ram #(.WIDTH(2 * WORD_BITS), .DEPTH(MAX_WORDS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rd_idx_q),
    .wdata_i (rem_wd),
    .raddr_i (ic_q),
    .rdata_o (rem_rd)
  );

  // One word of the shift and trial subtraction.
  assign first_w = (rd_idx_q == '0);
  assign last_w  = (rd_idx_q == nm1_q);
  assign rsel    = use_t_q ? rem_rd[2*WORD_BITS-1:WORD_BITS] : rem_rd[WORD_BITS-1:0];
  assign cin     = first_w ? dvd_rd[bpos_q] : carry_q;
  assign bin     = first_w ? 1'b0 : borrow_q;
  assign s_w     = {rsel[WORD_BITS-2:0], cin};
  assign {bo, t_w} = {1'b0, s_w} - {1'b0, dvs_rd} - {{WORD_BITS{1'b0}}, bin};

  always_comb begin
    rem_we = rd_vld_q && (state_q == S_INIT || state_q == S_BIT);
    rem_wd = (state_q == S_INIT) ? '0 : {t_w, s_w};
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    nm1_d     = nm1_q;
    ic_d      = ic_q;
    iss_d     = iss_q;
    rd_vld_d  = 1'b0;
    dword_d   = dword_q;
    bpos_d    = bpos_q;
    carry_d   = carry_q;
    borrow_d  = borrow_q;
    use_t_d   = use_t_q;
    nz_d      = nz_q;
    zero_d    = zero_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    // Read issue for the walking passes.
    if ((state_q == S_INIT || state_q == S_BIT) && iss_q) begin
      rd_vld_d = 1'b1;
      if (ic_q == nm1_q) begin
        iss_d = 1'b0;
      end else begin
        ic_d = ic_q + AW'(1);
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && in_word_i.action == mmr_pkg::ACT_COMPUTE) begin
          state_d = S_INIT;
          nm1_d   = AW'(n7 - 7'd1);
          ic_d    = '0;
          iss_d   = 1'b1;
          nz_d    = 1'b0;
          use_t_d = 1'b0;
          dword_d = AW'(n7 - 7'd1);
          bpos_d  = TOPB;
        end
      end
      S_INIT: begin
        if (rd_vld_q) begin
          nz_d = nz_q || (dvs_rd != '0);
          if (last_w) begin
            ic_d  = '0;
            if (nz_d) begin
              state_d = S_BIT;
              iss_d   = 1'b1;
              zero_d  = 1'b0;
            end else begin
              state_d = S_ERD;
              zero_d  = 1'b1;
            end
          end
        end
      end
      S_BIT: begin
        if (rd_vld_q) begin
          carry_d  = rsel[WORD_BITS-1];
          borrow_d = bo;
          if (last_w) begin
            use_t_d = rsel[WORD_BITS-1] || !bo;
            ic_d    = '0;
            if (bpos_q == '0 && dword_q == '0) begin
              state_d = S_ERD;
            end else begin
              iss_d = 1'b1;
              if (bpos_q == '0) begin
                bpos_d  = TOPB;
                dword_d = dword_q - AW'(1);
              end else begin
                bpos_d = bpos_q - BW'(1);
              end
            end
          end
        end
      end
      S_ERD: begin
        state_d = S_ELD;
      end
      S_ELD: begin
        out_d.remainder_word = zero_q ? DW'(dvd_rd) :
          DW'(use_t_q ? rem_rd[2*WORD_BITS-1:WORD_BITS] : rem_rd[WORD_BITS-1:0]);
        out_d.out_index    = 6'(ic_q);
        out_d.last_word    = (ic_q == nm1_q);
        out_d.zero_divisor = zero_q;
        out_vld_d = 1'b1;
        state_d   = S_EWT;
      end
      S_EWT: begin
        if (!out_stall_i) begin
          out_vld_d = 1'b0;
          if (ic_q == nm1_q) begin
            state_d = S_IDLE;
          end else begin
            ic_d    = ic_q + AW'(1);
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wiu_q     <= 7'd64;
      nm1_q     <= '0;
      ic_q      <= '0;
      iss_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      dword_q   <= '0;
      bpos_q    <= '0;
      carry_q   <= 1'b0;
      borrow_q  <= 1'b0;
      use_t_q   <= 1'b0;
      nz_q      <= 1'b0;
      zero_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) wiu_q <= cfg_wdata_i;
      nm1_q     <= nm1_d;
      ic_q      <= ic_d;
      iss_q     <= iss_d;
      rd_vld_q  <= rd_vld_d;
      rd_idx_q  <= ic_q;
      dword_q   <= dword_d;
      bpos_q    <= bpos_d;
      carry_q   <= carry_d;
      borrow_q  <= borrow_d;
      use_t_q   <= use_t_d;
      nz_q      <= nz_d;
      zero_q    <= zero_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/mmr_checker.sv =====
`include "assert_macros.svh"

module mmr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input mmr_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mmr_pkg::out_word_t out_word_o
);

  // A waiting remainder word holds still.
  `MMR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))

  // No new word is taken while remainder words are being delivered.
  `MMR_ASSERT_MSG(a_busy_emit, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input open during emit")

  // The last remainder word ends the burst.
  `MMR_ASSERT(a_last_ends, clk_i, rst_ni, out_valid_o && !out_stall_i && out_word_o.last_word |=> !out_valid_o)

  // A compute word closes the input at once.
  `MMR_ASSERT_MSG(a_compute_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && in_word_i.action == mmr_pkg::ACT_COMPUTE |=> in_stall_o, "compute did not stall input")

endmodule

bind multiword_modular_reduction mmr_checker u_mmr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
